[src/eec_pkg.sv]
// shared types, constants and the rounded q16 multiply of the elastic easing core
// no dependencies
package eec_pkg;

    localparam int TIME_BITS_DEF = 15;

    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [15:0] SPAN_FULL    = 16'd4096;
    localparam logic [15:0] SPAN_HALF    = 16'd2048;
    localparam logic [15:0] AMP_RESET    = 16'd1229;
    localparam logic [15:0] PER_RESET    = 16'd4096;
    localparam logic [14:0] QUARTER_TURN = 15'd16384;

    // sine polynomial coefficients, q16
    localparam logic [16:0] SIN_C1 = 17'd102944;
    localparam logic [16:0] SIN_C3 = 17'd42048;
    localparam logic [16:0] SIN_C5 = 17'd4640;
    // exp2 polynomial coefficients, q16
    localparam logic [16:0] EXP_C1 = 17'd45617;
    localparam logic [16:0] EXP_C2 = 17'd14712;
    localparam logic [16:0] EXP_C3 = 17'd5207;

    localparam int SIN_LAT       = 4;
    localparam int ASIN_STEPS    = 15;
    localparam int ASIN_CELL_LAT = SIN_LAT + 1;
    localparam int ASIN_LAT      = ASIN_STEPS * ASIN_CELL_LAT;
    localparam int DIV_BITS      = 29;
    localparam int EXP_LAT       = 3;
    localparam int E_W           = 20;
    localparam int D_W           = 31;
    localparam int X_W           = 29;
    localparam int AD_W          = 47;
    localparam int MAG_W         = 63;

    typedef enum logic [1:0] {
        OP_IN     = 2'd0,
        OP_OUT    = 2'd1,
        OP_IN_OUT = 2'd2,
        OP_OUT_IN = 2'd3
    } t_op;

    typedef enum logic {
        REG_AMPLITUDE = 1'b0,
        REG_PERIOD    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [14:0]    res;
        logic [15:0]    a;
        logic [X_W-1:0] x;
    } t_asin;

    typedef struct packed {
        logic [15:0]         p;
        logic [15:0]         rem;
        logic [DIV_BITS-1:0] m;
        logic [15:0]         q;
    } t_div;

    typedef struct packed {
        logic            fixed;
        logic            sub;
        logic            half;
        logic            neg;
        logic            uneg;
        logic            lo;
        logic [17:0]     base;
        logic [15:0]     a;
        logic [15:0]     q;
        logic [AD_W-1:0] ad;
    } t_side;

    typedef struct packed {
        t_side               side;
        logic [DIV_BITS-1:0] m;
        logic [E_W-1:0]      e;
        logic [15:0]         p;
        logic [X_W-1:0]      x;
    } t_front;

    // (a * b + 0.5) >> 16
    function automatic logic [17:0] mul_q16(input logic [16:0] a, input logic [16:0] b);
        logic [34:0] prod;
        prod = 35'(a) * 35'(b) + 35'd32768;
        return prod[33:16];
    endfunction

endpackage

[src/elastic_easing_curve_core.sv]
// Elastic easing curve core. One request (mode, time) is taken every cycle unless the
// pipeline stalls; its depth is set by the phase offset search, a chain of 15 cells
// of 5 stages each. Amplitude and period are written through the register port, by
// the user only between requests; the core does not enforce this. The pipeline only
// stalls when its last stage and the output register both hold results not taken.
// depends on eec_pkg, eec_sine, eec_asin_cell, eec_div_cell, eec_exp2
module elastic_easing_curve_core #(
    parameter int TIME_BITS = eec_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_operation,
    input  logic [TIME_BITS:0]   i_time_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [23:0]   o_value,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import eec_pkg::*;

    localparam int TW        = TIME_BITS + 1;
    localparam int TW1       = TW + 1;
    localparam int MU10_W    = TIME_BITS + 4;
    localparam int SIDE_LAST = ASIN_LAT + 1 + SIN_LAT;
    localparam int VLD_LAST  = SIDE_LAST + 1;
    localparam logic [TW-1:0]  T_ONE  = TW'(1) << TIME_BITS;
    localparam logic [TW1-1:0] T_ONE2 = TW1'(1) << TIME_BITS;
    localparam logic [TW1-1:0] T_TWO2 = TW1'(1) << TW;
    localparam logic signed [25:0] VAL_MAX = 26'sd8388607;
    localparam logic signed [25:0] VAL_MIN = -26'sd8388608;

    logic [15:0] r_amplitude, r_period;

    logic        w_en, w_out_take;
    logic        r_vld [0:VLD_LAST];
    t_front      r_s0;
    t_side       r_side [1:SIDE_LAST];
    t_front      w_f;

    // front stage
    logic [TW-1:0]        w_t;
    logic [TW1-1:0]       w_t2;
    logic [TIME_BITS-1:0] w_mu;
    logic [15:0]          w_span, w_p;
    logic [MU10_W-1:0]    w_mu10;
    logic [E_W-1:0]       w_e;

    assign w_t    = (i_time_req > T_ONE) ? T_ONE : i_time_req;
    assign w_t2   = {w_t, 1'b0};
    assign w_mu10 = MU10_W'(w_mu) * MU10_W'(10);

    if (TIME_BITS > 16) begin : g_e_down
        assign w_e = E_W'((w_mu10 + (MU10_W'(1) << (TIME_BITS - 17))) >> (TIME_BITS - 16));
    end else begin : g_e_up
        assign w_e = E_W'(w_mu10) << (16 - TIME_BITS);
    end

    always_comb begin
        w_f           = '0;
        w_mu          = '0;
        w_span        = SPAN_FULL;
        w_f.side.base = '0;
        unique case (t_op'(i_operation))
            OP_IN: begin
                w_mu          = TIME_BITS'(T_ONE - w_t);
                w_f.side.uneg = 1'b1;
                w_f.side.sub  = 1'b1;
            end
            OP_OUT: begin
                w_mu          = TIME_BITS'(w_t);
                w_f.side.base = 18'(Q16_ONE);
            end
            OP_IN_OUT: begin
                w_f.side.half = 1'b1;
                if (w_t2 < T_ONE2) begin
                    w_mu          = TIME_BITS'(T_ONE2 - w_t2);
                    w_f.side.uneg = 1'b1;
                    w_f.side.sub  = 1'b1;
                end else begin
                    w_mu          = TIME_BITS'(w_t2 - T_ONE2);
                    w_f.side.base = 18'(Q16_ONE);
                end
            end
            OP_OUT_IN: begin
                w_span        = SPAN_HALF;
                w_f.side.base = 18'd32768;
                if (w_t2 < T_ONE2) begin
                    w_mu = TIME_BITS'(w_t2);
                end else if (w_t2 == T_ONE2) begin
                    w_f.side.fixed = 1'b1;
                end else begin
                    w_mu          = TIME_BITS'(T_TWO2 - w_t2);
                    w_f.side.uneg = 1'b1;
                    w_f.side.sub  = 1'b1;
                end
            end
            default: ;
        endcase
        // exact endpoints
        if (w_t == '0) begin
            w_f.side.fixed = 1'b1;
            w_f.side.base  = '0;
        end else if (w_t == T_ONE) begin
            w_f.side.fixed = 1'b1;
            w_f.side.base  = 18'(Q16_ONE);
        end
        w_f.side.lo = r_amplitude < w_span;
        w_f.side.a  = w_f.side.lo ? w_span : r_amplitude;
        w_p         = (r_period == '0) ? 16'd1 : r_period;
        w_f.p       = w_p;
        w_f.x       = X_W'({w_span, 16'd0}) + X_W'(w_f.side.a[15:1]);
        // rounded phase quotient: (mu * 2^(28 - tb) + p/2) / p
        w_f.m       = (DIV_BITS'(w_mu) << (DIV_BITS - 1 - TIME_BITS)) + DIV_BITS'(w_p[15:1]);
        w_f.e       = w_e;
    end

    // offset search, divider and envelope run side by side from the front stage
    t_asin          w_asin [0:ASIN_STEPS];
    t_div           w_div  [0:DIV_BITS];
    logic [D_W-1:0] w_exp_d;

    assign w_asin[0] = '{res: '0, a: r_s0.side.a, x: r_s0.x};
    assign w_div[0]  = '{p: r_s0.p, rem: '0, m: r_s0.m, q: '0};

    for (genvar i = 0; i < ASIN_STEPS; i++) begin : g_asin
        eec_asin_cell #(.BIT(ASIN_STEPS - 1 - i)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_asin[i]),
            .o_d   (w_asin[i+1])
        );
    end

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
        eec_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_div[i]),
            .o_d   (w_div[i+1])
        );
    end

    eec_exp2 u_exp2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_e   (r_s0.e),
        .o_d   (w_exp_d)
    );

    // phase: wrap, negate for negative time, subtract offset, fold to a quarter wave
    logic [15:0] w_sp, w_ph, w_ph2;
    logic [14:0] w_f14;
    logic [16:0] w_y, r_y, w_s;

    assign w_sp  = r_side[ASIN_LAT].lo ? 16'(QUARTER_TURN) : 16'(w_asin[ASIN_STEPS].res);
    assign w_ph  = r_side[ASIN_LAT].uneg ? (16'd0 - r_side[ASIN_LAT].q) : r_side[ASIN_LAT].q;
    assign w_ph2 = w_ph - w_sp;
    assign w_f14 = w_ph2[14] ? (15'h4000 - {1'b0, w_ph2[13:0]}) : {1'b0, w_ph2[13:0]};
    assign w_y   = {w_f14, 2'b00};

    eec_sine u_sine (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_y),
        .o_s   (w_s)
    );

    // side data shifts along; results of the side units join their request here
    t_side n_side [1:SIDE_LAST];

    always_comb begin
        n_side[1] = r_s0.side;
        for (int k = 2; k <= SIDE_LAST; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[EXP_LAT+1].ad   = AD_W'(w_exp_d);
        n_side[EXP_LAT+2].ad   = AD_W'(r_side[EXP_LAT+1].a) *
                                 AD_W'(r_side[EXP_LAT+1].ad[D_W-1:0]);
        n_side[DIV_BITS+1].q   = w_div[DIV_BITS].q;
        n_side[ASIN_LAT+1].neg = w_ph2[15];
    end

    // final term and output
    logic [MAG_W-1:0]   r_mag, w_rnd;
    t_side              r_fin;
    logic [21:0]        w_tm;
    logic signed [25:0] w_term, w_v, w_base;
    logic signed [23:0] r_value;
    logic               r_out_vld;

    assign w_rnd  = r_fin.half ? (r_mag + (MAG_W'(1) << 42)) : (r_mag + (MAG_W'(1) << 41));
    assign w_tm   = r_fin.half ? 22'(w_rnd >> 43) : 22'(w_rnd >> 42);
    assign w_term = r_fin.neg ? -$signed({4'd0, w_tm}) : $signed({4'd0, w_tm});
    assign w_base = $signed({8'd0, r_fin.base});

    always_comb begin
        priority if (r_fin.fixed) begin
            w_v = w_base;
        end else if (r_fin.sub) begin
            w_v = w_base - w_term;
        end else begin
            w_v = w_base + w_term;
        end
    end

    assign w_out_take = !r_out_vld || i_out_ready;
    assign w_en       = w_out_take || !r_vld[VLD_LAST];
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= AMP_RESET;
            r_period    <= PER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_AMPLITUDE: r_amplitude <= i_cfg_data;
                REG_PERIOD:    r_period    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= VLD_LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k <= VLD_LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= w_f;
            for (int k = 1; k <= SIDE_LAST; k++) begin
                r_side[k] <= n_side[k];
            end
            r_y   <= w_y;
            r_mag <= MAG_W'(r_side[SIDE_LAST].ad) * MAG_W'(w_s);
            r_fin <= r_side[SIDE_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_take) begin
            r_out_vld <= r_vld[VLD_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && r_vld[VLD_LAST]) begin
            priority if (w_v > VAL_MAX) begin
                r_value <= 24'sh7FFFFF;
            end else if (w_v < VAL_MIN) begin
                r_value <= -24'sh800000;
            end else begin
                r_value <= w_v[23:0];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_value     = r_value;

endmodule

[src/eec_sine.sv]
// pipelined quarter-wave sine, odd quintic in q16, four register stages
// depends on eec_pkg
module eec_sine (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_y,
    output logic [16:0] o_s
);
    import eec_pkg::*;

    logic [16:0] r_y1, r_y2a, r_y3;
    logic [16:0] r_sq1, r_sq2;
    logic [16:0] r_t, r_t2, r_s;
    logic [17:0] w_sq, w_m1, w_m2, w_m3;

    assign w_sq = mul_q16(i_y, i_y);
    assign w_m1 = mul_q16(SIN_C5, r_sq1);
    assign w_m2 = mul_q16(r_t, r_sq2);
    assign w_m3 = mul_q16(r_t2, r_y3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y1  <= i_y;
            r_sq1 <= w_sq[16:0];
            r_y2a <= r_y1;
            r_sq2 <= r_sq1;
            r_t   <= SIN_C3 - w_m1[16:0];
            r_y3  <= r_y2a;
            r_t2  <= SIN_C1 - w_m2[16:0];
            r_s   <= (w_m3 > 18'(Q16_ONE)) ? Q16_ONE : w_m3[16:0];
        end
    end

    assign o_s = r_s;

endmodule

[src/eec_asin_cell.sv]
// one step of the phase offset bit search: sine of the candidate, then scaled compare
// depends on eec_pkg and eec_sine
module eec_asin_cell #(
    parameter int BIT = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  eec_pkg::t_asin i_d,
    output eec_pkg::t_asin o_d
);
    import eec_pkg::*;

    logic [14:0] w_cand;
    logic [16:0] w_s;
    logic [32:0] w_prod;
    logic        w_take;
    t_asin       w_next;
    t_asin       r_dly  [SIN_LAT];
    logic [14:0] r_cand [SIN_LAT];
    t_asin       r_out;

    assign w_cand = i_d.res | (15'd1 << BIT);

    eec_sine u_sine (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_y   ({w_cand, 2'b00}),
        .o_s   (w_s)
    );

    // candidate kept only if it stays within a quarter turn and s*a <= span + a/2
    assign w_prod = 33'(w_s) * 33'(r_dly[SIN_LAT-1].a);
    assign w_take = (r_cand[SIN_LAT-1] <= QUARTER_TURN) &&
                    (w_prod <= 33'(r_dly[SIN_LAT-1].x));

    always_comb begin
        w_next     = r_dly[SIN_LAT-1];
        w_next.res = w_take ? r_cand[SIN_LAT-1] : r_dly[SIN_LAT-1].res;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0]  <= i_d;
            r_cand[0] <= w_cand;
            for (int k = 1; k < SIN_LAT; k++) begin
                r_dly[k]  <= r_dly[k-1];
                r_cand[k] <= r_cand[k-1];
            end
            r_out <= w_next;
        end
    end

    assign o_d = r_out;

endmodule

[src/eec_div_cell.sv]
// one restoring division step, one quotient bit per cell
// depends on eec_pkg
module eec_div_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  eec_pkg::t_div i_d,
    output eec_pkg::t_div o_d
);
    import eec_pkg::*;

    logic [16:0] w_r;
    logic        w_ge;
    logic [16:0] w_diff;
    t_div        r_out;

    assign w_r    = {i_d.rem, i_d.m[DIV_BITS-1]};
    assign w_ge   = w_r >= {1'b0, i_d.p};
    assign w_diff = w_r - {1'b0, i_d.p};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.p   <= i_d.p;
            r_out.rem <= w_ge ? w_diff[15:0] : w_r[15:0];
            r_out.m   <= {i_d.m[DIV_BITS-2:0], 1'b0};
            r_out.q   <= {i_d.q[14:0], w_ge};
        end
    end

    assign o_d = r_out;

endmodule

[src/eec_exp2.sv]
// pipelined 2^(-e) in q30 from a q16 exponent, cubic in the fraction
// depends on eec_pkg
module eec_exp2 (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [eec_pkg::E_W-1:0] i_e,
    output logic [eec_pkg::D_W-1:0] o_d
);
    import eec_pkg::*;

    logic [16:0]    w_g;
    logic [17:0]    w_m1, w_m2, w_m3;
    logic [17:0]    w_pp;
    logic [16:0]    r_g1, r_g2;
    logic [3:0]     r_k1, r_k2;
    logic [16:0]    r_a1, r_a2;
    logic [D_W-1:0] r_d;

    assign w_g  = Q16_ONE - {1'b0, i_e[15:0]};
    assign w_m1 = mul_q16(w_g, EXP_C3);
    assign w_m2 = mul_q16(r_g1, r_a1);
    assign w_m3 = mul_q16(r_g2, r_a2);
    assign w_pp = 18'(Q16_ONE) + w_m3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1 <= w_g;
            r_k1 <= i_e[E_W-1:16];
            r_a1 <= EXP_C2 + w_m1[16:0];
            r_g2 <= r_g1;
            r_k2 <= r_k1;
            r_a2 <= EXP_C1 + w_m2[16:0];
            r_d  <= (r_k2 > 4'd12) ? '0 : (D_W'(w_pp) << (4'd13 - r_k2));
        end
    end

    assign o_d = r_d;

endmodule
